// ===== src/eucd_pkg.sv =====
package eucd_pkg;

  localparam int ACC_BITS           = 44;
  localparam int DIST_BITS          = 30;
  localparam int COORD_BITS_DEFAULT = 16;
  localparam int FRACTION_BITS_DEF  = 8;

  localparam logic [ACC_BITS-1:0]  ACC_MAX  = '1;
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;    // register the square of the accepted word
    logic finish;  // fold the last square, move the sum to the root unit, clear
    logic step;    // one root iteration
    logic load;    // load the result register
  } eucd_cmd_t;

endpackage

// ===== src/euclidean_distance.sv =====
// Euclidean distance: takes one coordinate word per cycle and accumulates squares.
// After a last-dimension word, in_ready drops while the result is formed: the drain
// state folds the last square, a restoring root unit retires one of ROOT_W result bits
// (ROOT_W = 30 by default) per cycle, and the write state loads the result. out_valid
// rises in the cycle after the load, which waits until out_ready takes any held result.
// Synchronous active-low reset clears the sum, overflow flag and control state.
module euclidean_distance #(
  parameter int COORD_BITS    = eucd_pkg::COORD_BITS_DEFAULT,
  parameter int FRACTION_BITS = eucd_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [COORD_BITS-1:0]   in_point_coord,
  input  logic signed [COORD_BITS-1:0]   in_query_coord,
  input  logic                           in_last_element,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [eucd_pkg::DIST_BITS-1:0] out_distance,
  output logic                           out_overflow
);
  import eucd_pkg::*;

  eucd_cmd_t cmd;

  eucd_ctrl #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_last_element (in_last_element),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cmd             (cmd)
  );

  eucd_dp #(
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_point_coord (in_point_coord),
    .in_query_coord (in_query_coord),
    .out_distance   (out_distance),
    .out_overflow   (out_overflow)
  );

endmodule

// ===== src/eucd_dp.sv =====
module eucd_dp #(
  parameter int COORD_BITS    = eucd_pkg::COORD_BITS_DEFAULT,
  parameter int FRACTION_BITS = eucd_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  eucd_pkg::eucd_cmd_t           cmd,
  input  logic signed [COORD_BITS-1:0]  in_point_coord,
  input  logic signed [COORD_BITS-1:0]  in_query_coord,
  output logic [eucd_pkg::DIST_BITS-1:0] out_distance,
  output logic                          out_overflow
);
  import eucd_pkg::*;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int SUM_W  = ((SQ_W > ACC_BITS) ? SQ_W : ACC_BITS) + 1;
  localparam int ROOT_W = (ACC_BITS + 2 * FRACTION_BITS + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int EXT_W  = (ROOT_W > DIST_BITS) ? ROOT_W : DIST_BITS;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag;
  logic [SQ_W-1:0]          sq_nxt;
  logic [SUM_W-1:0]         sum_ext;
  logic                     over;
  logic [ACC_BITS-1:0]      sum_sat;
  logic [REM_W-1:0]         rem_t;
  logic [REM_W-1:0]         trial;
  logic                     fits;
  logic [EXT_W-1:0]         root_ext;
  logic [DIST_BITS-1:0]     dist_nxt;

  logic [SQ_W-1:0]      sq_r;
  logic                 sq_vld_r;
  logic [ACC_BITS-1:0]  acc_r;
  logic                 sat_r;
  logic [RAD_W-1:0]     rad_r;
  logic [REM_W-1:0]     rem_r;
  logic [ROOT_W-1:0]    root_r;
  logic                 ovf_hold_r;
  logic [DIST_BITS-1:0] dist_r;
  logic                 ovf_r;

  always_comb begin
    diff   = DIFF_W'(in_point_coord) - DIFF_W'(in_query_coord);
    mag    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    sq_nxt = SQ_W'(mag) * SQ_W'(mag);
  end

  // Saturating accumulate of the registered square
  always_comb begin
    sum_ext = SUM_W'(acc_r) + SUM_W'(sq_r);
    over    = sum_ext > SUM_W'(ACC_MAX);
    sum_sat = over ? ACC_MAX : sum_ext[ACC_BITS-1:0];
  end

  // Restoring square root: two radicand bits per step
  always_comb begin
    rem_t = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial = {root_r, 2'b01};
    fits  = rem_t >= trial;
  end

  always_comb begin
    root_ext = EXT_W'(root_r);
    if (root_ext > EXT_W'(DIST_MAX)) begin
      dist_nxt = DIST_MAX;
    end else begin
      dist_nxt = root_ext[DIST_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
      acc_r    <= '0;
      sat_r    <= 1'b0;
    end else begin
      sq_vld_r <= cmd.take;
      if (cmd.finish) begin
        acc_r <= '0;
        sat_r <= 1'b0;
      end else if (sq_vld_r) begin
        acc_r <= sum_sat;
        sat_r <= sat_r | over;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sq_r <= sq_nxt;
    end
    if (cmd.finish) begin
      rad_r      <= RAD_W'(sum_sat) << (2 * FRACTION_BITS);
      rem_r      <= '0;
      root_r     <= '0;
      ovf_hold_r <= sat_r | over;
    end else if (cmd.step) begin
      rad_r  <= rad_r << 2;
      rem_r  <= fits ? (rem_t - trial) : rem_t;
      root_r <= {root_r[ROOT_W-2:0], fits};
    end
    if (cmd.load) begin
      dist_r <= dist_nxt;
      ovf_r  <= ovf_hold_r;
    end
  end

  assign out_distance = dist_r;
  assign out_overflow = ovf_r;

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (acc_r == '0) && !sat_r)
    else $error("accumulator not cleared after vector end");

  a_finish_has_square: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sq_vld_r)
    else $error("vector end without its last square");

  a_no_take_in_root: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !cmd.take && !sq_vld_r)
    else $error("word taken while the root unit runs");

endmodule

// ===== src/eucd_ctrl.sv =====
module eucd_ctrl #(
  parameter int FRACTION_BITS = eucd_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last_element,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output eucd_pkg::eucd_cmd_t cmd
);
  import eucd_pkg::*;

  localparam int ROOT_W = (ACC_BITS + 2 * FRACTION_BITS + 1) / 2;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  localparam logic [1:0] ST_ACC   = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_SQRT  = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    in_ready   = state_r == ST_ACC;
    cmd.take   = in_valid && in_ready;
    cmd.finish = state_r == ST_DRAIN;
    cmd.step   = state_r == ST_SQRT;
    cmd.load   = (state_r == ST_WRITE) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_ACC: begin
        if (cmd.take && in_last_element) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        cnt_nxt   = CNT_W'(ROOT_W);
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (cmd.load) state_nxt = ST_ACC;
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  // Hold the result until taken; a fresh load wins over the drop
  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_load_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !out_valid_r || out_ready)
    else $error("result overwritten before taken");

  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> cnt_r != '0)
    else $error("root step with empty count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before taken");

endmodule
